FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks with an active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PRIT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property failed");

`define PRIT_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");

`else

`define PRIT_ASSERT(label, clk, rstn, prop)

`define PRIT_ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

FILE: rtl/prit_pkg.sv
// ----------------------------------------------------------------------------
// prit_pkg
// field widths, operation codes and status codes of the page run index table
// ----------------------------------------------------------------------------
package prit_pkg;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 18;

    localparam logic [OP_W-1:0] OP_CLEAR    = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

endpackage

FILE: rtl/page_run_index_table.sv
// ----------------------------------------------------------------------------
// page_run_index_table
// sorted table of physical page runs that maps a physical address to a
// byte offset within the buffer
// ----------------------------------------------------------------------------
// One item is handled at a time. A clear, an unused op or an add to a full
// table goes straight to the response. An add to a non-empty table scans
// the runs that start below the new address, then either merges into the
// run just below the slot or moves the runs above it up and writes there.
// A lookup reads the runs in order until one matches or the last run has
// been read. The scan, the search and the shift all use the single run
// memory, which gives one entry per cycle. No clearing pass: the run count
// alone marks valid entries.
// A result waits in an output register; the next item is taken meanwhile.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_run_index_table #(
    parameter int MAX_PAGES = 64,
    parameter int PAGE_SIZE = 4096
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [prit_pkg::OP_W-1:0]         s_op,
    input  logic [prit_pkg::ADDR_W-1:0]       s_addr,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prit_pkg::STATUS_W-1:0]     m_status,
    output logic [prit_pkg::OFFSET_W-1:0]     m_offset,
    output logic                              m_merged
);

    localparam int ADDR_W = prit_pkg::ADDR_W;
    localparam int IDX_W  = $clog2(MAX_PAGES);
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int LEN_W  = $clog2(MAX_PAGES * PAGE_SIZE + 1);
    localparam int OFF_W  = $clog2(MAX_PAGES * PAGE_SIZE);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAGES);
    localparam logic [LEN_W-1:0] STEP    = LEN_W'(PAGE_SIZE);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;
    localparam logic [2:0] S_LOOK   = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } entry_t;

    // run memory
    entry_t mem [MAX_PAGES];

    logic                            we;
    logic [IDX_W-1:0]                wa;
    entry_t                          wd;
    logic [IDX_W-1:0]                rd_addr;
    entry_t                          rd_data_reg;

    logic [2:0]                      state_reg, state_next;
    logic [ADDR_W-1:0]               addr_reg, addr_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    entry_t                          prev_reg, prev_next;
    logic                            has_prev_reg, has_prev_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                pages_reg, pages_next;
    logic [LEN_W-1:0]                page_off_reg, page_off_next;
    logic [prit_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [prit_pkg::OFFSET_W-1:0]   res_offset_reg, res_offset_next;
    logic                            res_merged_reg, res_merged_next;
    logic                            m_valid_reg, m_valid_next;
    logic [prit_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [prit_pkg::OFFSET_W-1:0]   m_offset_reg, m_offset_next;
    logic                            m_merged_reg, m_merged_next;

    logic                            addr_gt;
    logic [ADDR_W:0]                 cur_end;
    logic                            hit;
    logic [ADDR_W-1:0]               hit_off;
    logic [CNT_W-1:0]                idx_inc;
    logic [CNT_W-1:0]                idx_dec;
    logic [CNT_W-1:0]                pos_dec;
    logic [CNT_W-1:0]                cnt_dec;
    logic                            last;
    logic [LEN_W:0]                  prev_end_off;
    logic [ADDR_W:0]                 prev_end_addr;
    logic                            do_merge;
    logic                            full;
    entry_t                          grown;
    entry_t                          fresh;
    logic                            shift_in_range;
    logic                            clear_taken;
    logic                            table_empty;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // compare logic on the entry just read
    assign addr_gt  = addr_reg > rd_data_reg.start;
    assign cur_end  = {1'b0, rd_data_reg.start} + (ADDR_W + 1)'(rd_data_reg.length);
    assign hit      = (addr_reg >= rd_data_reg.start) && ({1'b0, addr_reg} < cur_end);
    assign hit_off  = ADDR_W'(rd_data_reg.offset) + (addr_reg - rd_data_reg.start);
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign pos_dec  = pos_reg - 1'b1;
    assign cnt_dec  = count_reg - 1'b1;
    assign last     = idx_inc == count_reg;

    // merge test against the run just below the slot
    assign prev_end_off  = (LEN_W + 1)'(prev_reg.offset) + (LEN_W + 1)'(prev_reg.length);
    assign prev_end_addr = {1'b0, prev_reg.start} + (ADDR_W + 1)'(prev_reg.length);
    assign do_merge = has_prev_reg && ({1'b0, page_off_reg} == prev_end_off)
                      && ({1'b0, addr_reg} == prev_end_addr);
    assign full     = (pages_reg >= MAX_CNT) || (count_reg >= MAX_CNT);

    always_comb begin
        grown        = prev_reg;
        grown.length = prev_reg.length + STEP;
        fresh.start  = addr_reg;
        fresh.offset = OFF_W'(page_off_reg);
        fresh.length = STEP;
    end

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        prev_next       = prev_reg;
        has_prev_next   = has_prev_reg;
        count_next      = count_reg;
        pages_next      = pages_reg;
        page_off_next   = page_off_reg;
        res_status_next = res_status_reg;
        res_offset_next = res_offset_reg;
        res_merged_next = res_merged_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_offset_next   = m_offset_reg;
        m_merged_next   = m_merged_reg;
        we              = 1'b0;
        wa              = '0;
        wd              = fresh;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    addr_next       = s_addr;
                    idx_next        = '0;
                    has_prev_next   = 1'b0;
                    res_status_next = prit_pkg::STATUS_OK;
                    res_offset_next = '0;
                    res_merged_next = 1'b0;
                    unique case (s_op)
                        prit_pkg::OP_CLEAR: begin
                            count_next    = '0;
                            pages_next    = '0;
                            page_off_next = '0;
                            state_next    = S_RESP;
                        end
                        prit_pkg::OP_ADD: begin
                            if (full) begin
                                res_status_next = prit_pkg::STATUS_FULL;
                                state_next      = S_RESP;
                            end else if (count_reg == '0) begin
                                pos_next   = '0;
                                state_next = S_INSERT;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        prit_pkg::OP_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_status_next = prit_pkg::STATUS_NOT_FOUND;
                                state_next      = S_RESP;
                            end else begin
                                state_next = S_LOOK;
                            end
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (addr_gt) begin
                    prev_next     = rd_data_reg;
                    has_prev_next = 1'b1;
                    if (last) begin
                        pos_next   = count_reg;
                        state_next = S_DECIDE;
                    end else begin
                        idx_next = idx_inc;
                        rd_addr  = idx_inc[IDX_W-1:0];
                    end
                end else begin
                    pos_next   = idx_reg;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (do_merge) begin
                    we              = 1'b1;
                    wa              = pos_dec[IDX_W-1:0];
                    wd              = grown;
                    pages_next      = pages_reg + 1'b1;
                    page_off_next   = page_off_reg + STEP;
                    res_merged_next = 1'b1;
                    state_next      = S_RESP;
                end else if (pos_reg == count_reg) begin
                    state_next = S_INSERT;
                end else begin
                    idx_next   = cnt_dec;
                    rd_addr    = cnt_dec[IDX_W-1:0];
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                we = 1'b1;
                wa = idx_inc[IDX_W-1:0];
                wd = rd_data_reg;
                if (idx_reg == pos_reg) begin
                    state_next = S_INSERT;
                end else begin
                    idx_next = idx_dec;
                    rd_addr  = idx_dec[IDX_W-1:0];
                end
            end
            S_INSERT: begin
                we            = 1'b1;
                wa            = pos_reg[IDX_W-1:0];
                wd            = fresh;
                count_next    = count_reg + 1'b1;
                pages_next    = pages_reg + 1'b1;
                page_off_next = page_off_reg + STEP;
                state_next    = S_RESP;
            end
            S_LOOK: begin
                if (hit) begin
                    res_offset_next = hit_off[prit_pkg::OFFSET_W-1:0];
                    state_next      = S_RESP;
                end else if (last) begin
                    res_status_next = prit_pkg::STATUS_NOT_FOUND;
                    state_next      = S_RESP;
                end else begin
                    idx_next = idx_inc;
                    rd_addr  = idx_inc[IDX_W-1:0];
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_offset_next = res_offset_reg;
                    m_merged_next = res_merged_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pages_reg    <= '0;
            page_off_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pages_reg    <= pages_next;
            page_off_reg <= page_off_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        has_prev_reg   <= has_prev_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_merged_reg <= res_merged_next;
        m_status_reg   <= m_status_next;
        m_offset_reg   <= m_offset_next;
        m_merged_reg   <= m_merged_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_offset = m_offset_reg;
    assign m_merged = m_merged_reg;

    assign shift_in_range = (idx_reg >= pos_reg) && (idx_reg < count_reg);
    assign clear_taken    = s_valid && s_ready && (s_op == prit_pkg::OP_CLEAR);
    assign table_empty    = (count_reg == '0) && (pages_reg == '0);

    `PRIT_ASSERT_NEVER(a_runs_within_pages, aclk, aresetn, count_reg > pages_reg)
    `PRIT_ASSERT_NEVER(a_pages_within_max, aclk, aresetn, pages_reg > MAX_CNT)
    `PRIT_ASSERT(a_shift_range, aclk, aresetn, (state_reg == S_SHIFT) |-> shift_in_range)
    `PRIT_ASSERT(a_clear_empties, aclk, aresetn, clear_taken |=> table_empty)

endmodule
